[sv/assert_macros.svh]
// Assertion macros shared by the URL percent decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed: next-cycle implication");

`endif

[sv/upd_pkg.sv]
// Package of the URL percent decoder: characters, types and hex digit decode.
`default_nettype none

package upd_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned NIBBLE_W = 4;

   localparam logic [BYTE_W-1:0] CHAR_PERCENT = 8'h25;
   localparam logic [BYTE_W-1:0] CHAR_PLUS    = 8'h2B;
   localparam logic [BYTE_W-1:0] CHAR_SPACE   = 8'h20;
   localparam logic [BYTE_W-1:0] CHAR_ZERO    = 8'h30;
   localparam logic [BYTE_W-1:0] CHAR_NINE    = 8'h39;
   localparam logic [BYTE_W-1:0] CHAR_LOW_A   = 8'h61;
   localparam logic [BYTE_W-1:0] CHAR_LOW_F   = 8'h66;
   localparam logic [BYTE_W-1:0] CHAR_UP_A    = 8'h41;
   localparam logic [BYTE_W-1:0] CHAR_UP_F    = 8'h46;
   localparam logic [BYTE_W-1:0] DIGIT_TEN    = 8'd10;
   localparam logic [BYTE_W-1:0] BAD_ESCAPE   = 8'hFF;

   // Decoder result for one request.
   typedef struct packed {
      logic              present;
      logic [BYTE_W-1:0] data;
      logic              data_valid;
      logic              last;
   } upd_result_type;

   // Decoder status seen by the top level.
   typedef struct packed {
      logic idle;
   } upd_status_type;

   // Hex digit decode: bit 4 set when the character is not a hex digit.
   function automatic logic [NIBBLE_W:0] hex_value(input logic [BYTE_W-1:0] c);
      logic [BYTE_W-1:0] diff;
      diff = '0;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         diff = c - CHAR_ZERO;
         return {1'b0, diff[NIBBLE_W-1:0]};
      end else if (c >= CHAR_LOW_A && c <= CHAR_LOW_F) begin
         diff = c - CHAR_LOW_A + DIGIT_TEN;
         return {1'b0, diff[NIBBLE_W-1:0]};
      end else if (c >= CHAR_UP_A && c <= CHAR_UP_F) begin
         diff = c - CHAR_UP_A + DIGIT_TEN;
         return {1'b0, diff[NIBBLE_W-1:0]};
      end
      return {1'b1, {NIBBLE_W{1'b0}}};
   endfunction

endpackage

`default_nettype wire

[sv/upd_decode.sv]
// Escape state machine and byte decode of the URL percent decoder.
`default_nettype none

module upd_decode (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic [upd_pkg::BYTE_W-1:0]   in_data,
   input  wire logic                         in_last,
   input  wire logic                         step,
   output upd_pkg::upd_result_type           result,
   output upd_pkg::upd_status_type           status
);

   typedef enum logic [2:0] {
      PH_IDLE = 3'b001,
      PH_HIGH = 3'b010,
      PH_LOW  = 3'b100
   } phase_type;

   phase_type                        phase_ff, phase_in;
   logic [upd_pkg::NIBBLE_W-1:0]     nibble_ff, nibble_in;
   logic [upd_pkg::NIBBLE_W:0]       digit;
   logic                             have;
   logic [upd_pkg::BYTE_W-1:0]       value;

   assign digit = upd_pkg::hex_value(in_data);

   always_comb begin
      phase_in  = PH_IDLE;
      nibble_in = nibble_ff;
      have      = 1'b0;
      value     = '0;
      unique case (phase_ff)
         PH_HIGH: begin
            nibble_in = digit[upd_pkg::NIBBLE_W] ? '1 : digit[upd_pkg::NIBBLE_W-1:0];
            phase_in  = PH_LOW;
         end
         PH_LOW: begin
            have  = 1'b1;
            value = digit[upd_pkg::NIBBLE_W] ? upd_pkg::BAD_ESCAPE
                                             : {nibble_ff, digit[upd_pkg::NIBBLE_W-1:0]};
         end
         default: begin
            if (in_data == upd_pkg::CHAR_PERCENT) begin
               phase_in = PH_HIGH;
            end else if (in_data == upd_pkg::CHAR_PLUS) begin
               have  = 1'b1;
               value = upd_pkg::CHAR_SPACE;
            end else begin
               have  = 1'b1;
               value = in_data;
            end
         end
      endcase
      if (in_last) begin
         phase_in  = PH_IDLE;
         nibble_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         nibble_ff <= '0;
      end else if (step) begin
         phase_ff  <= phase_in;
         nibble_ff <= nibble_in;
      end
   end

   assign result.present    = have | in_last;
   assign result.data       = value;
   assign result.data_valid = have;
   assign result.last       = in_last;
   assign status.idle       = (phase_ff == PH_IDLE);

endmodule

`default_nettype wire

[sv/url_percent_decoder.sv]
// Top level of the URL percent decoder: request register, decode and response register.
`default_nettype none
`include "assert_macros.svh"

// URL percent decoder. Takes one encoded character per request and returns
// decoded bytes: '+' becomes a space, "%hh" becomes one byte, anything else
// passes through. The request marked last always yields a response with
// rsp_out_last set; rsp_byte_valid tells whether it also carries a byte.
// Takes one request per cycle unless req_stall is high. A request passes
// the request register, the single decode stage and the response register
// before its response appears. '%' and the high hex digit of an escape
// give no response unless last. rsp_stall holds the response register
// and, once the request register is full behind it, raises req_stall.

module url_percent_decoder (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic [upd_pkg::BYTE_W-1:0] req_in_byte,
   input  wire logic                       req_in_last,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic [upd_pkg::BYTE_W-1:0]      rsp_out_byte,
   output logic                            rsp_byte_valid,
   output logic                            rsp_out_last
);

   logic                         s1_valid_ff, s1_valid_in;
   logic [upd_pkg::BYTE_W-1:0]   s1_data_ff;
   logic                         s1_last_ff;
   logic                         out_valid_ff, out_valid_in;
   logic [upd_pkg::BYTE_W-1:0]   out_data_ff;
   logic                         out_dvalid_ff;
   logic                         out_last_ff;
   logic                         out_free;
   logic                         consume;
   logic                         req_take;
   upd_pkg::upd_result_type      dec_result;
   upd_pkg::upd_status_type      dec_status;

   upd_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .in_data (s1_data_ff),
      .in_last (s1_last_ff),
      .step    (consume),
      .result  (dec_result),
      .status  (dec_status)
   );

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign consume   = s1_valid_ff && (!dec_result.present || out_free);
   assign req_stall = s1_valid_ff && !consume;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (consume) begin
         s1_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (consume && dec_result.present) begin
         out_valid_in = 1'b1;
      end else if (out_free) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_data_ff <= req_in_byte;
         s1_last_ff <= req_in_last;
      end
      if (consume && dec_result.present) begin
         out_data_ff   <= dec_result.data;
         out_dvalid_ff <= dec_result.data_valid;
         out_last_ff   <= dec_result.last;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_out_byte   = out_data_ff;
   assign rsp_byte_valid = out_dvalid_ff;
   assign rsp_out_last   = out_last_ff;

   // A response with no byte only closes a string.
   `ASSERT_IMPLIES(a_empty_is_last, clock, reset,
      rsp_valid && !rsp_byte_valid, rsp_out_last && rsp_out_byte == '0)
   // The decoder leaves any escape once the last request is decoded.
   `ASSERT_NEXT(a_last_clears_escape, clock, reset,
      consume && s1_last_ff, dec_status.idle)
   // A full response register that is stalled never takes a new result.
   `ASSERT_IMPLIES(a_no_overwrite, clock, reset,
      out_valid_ff && rsp_stall, !(consume && dec_result.present))

endmodule

`default_nettype wire
